### hdl/pgnh_pkg.sv
// Shared types and constants for the path geofence nearest-hit block.
package pgnh_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned LenW = 32;
  localparam int unsigned FarW = 33;
  localparam int unsigned BndW = 16;
  localparam int unsigned SqW = 48;            // one squared coordinate difference
  localparam int unsigned DistW = 49;          // sum of two squares
  localparam int unsigned RadW = 50;           // even width for two-bit digits
  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned RemW = RootW + 2;
  localparam int unsigned SqrtSteps = RootW;
  localparam int unsigned StepW = $clog2(SqrtSteps + 1);

  localparam logic [LenW-1:0] FarLimit = 32'd76544;
  localparam logic signed [FarW-1:0] FarNone = -33'sd25600;
  localparam logic signed [CoordW-1:0] DefaultPos = 24'sd768000;

  localparam logic [BndW-1:0] InnerReset = 16'd410;
  localparam logic [BndW-1:0] WideReset = 16'd538;
  localparam logic [LenW-1:0] TriggerReset = 32'd25344;
  localparam logic [LenW-1:0] NoHitReset = 32'd76800;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_POINT  = 2'd2,
    ACT_NONE   = 2'd3
  } pgnh_act_e;

  typedef enum logic [1:0] {
    REG_INNER   = 2'd0,
    REG_WIDE    = 2'd1,
    REG_TRIGGER = 2'd2,
    REG_NOHIT   = 2'd3
  } pgnh_reg_e;

  typedef struct packed {
    logic capture;
    logic clr_count;
    logic rd_prev;
    logic scan_init;
    logic scan_issue;
    logic sqrt_step;
    logic wr_vertex;
    logic fold;
    logic load_out;
  } pgnh_cmd_t;

  typedef struct packed {
    pgnh_act_e action;
    logic      last;
    logic      cnt_zero;
    logic      cnt_full;
    logic      scan_last;
    logic      pipe_busy;
    logic      sq_ready;
    logic      out_free;
  } pgnh_stat_t;

endpackage

### hdl/pgnh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pgnh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pgnh_datapath.sv
// Datapath: vertex store, distance pipeline, square root unit, running values, result word.
module pgnh_datapath
  import pgnh_pkg::*;
#(
  parameter int unsigned PathDepth = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pgnh_cmd_t                cmd_i,
  output pgnh_stat_t               stat_o,
  input  logic [1:0]               action_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [SpeedW-1:0] obj_speed_in_i,
  input  logic                     frame_last_i,
  input  logic [BndW-1:0]          inner_bnd_i,
  input  logic [BndW-1:0]          wide_bnd_i,
  input  logic [LenW-1:0]          trig_lim_i,
  input  logic [LenW-1:0]          no_hit_i,
  input  logic                     out_stall_i,
  output logic                     out_valid_o,
  output logic                     status_o,
  output logic                     trigger_o,
  output logic [LenW-1:0]          path_distance_o,
  output logic [LenW-1:0]          wide_distance_o,
  output logic signed [FarW-1:0]   farthest_o,
  output logic signed [SpeedW-1:0] nearest_speed_o,
  output logic signed [CoordW-1:0] hit_x_o,
  output logic signed [CoordW-1:0] hit_y_o
);

  localparam int unsigned AW = $clog2(PathDepth);
  localparam int unsigned CW = $clog2(PathDepth + 1);
  localparam int unsigned VW = 2 * CoordW + LenW;
  localparam logic [CW-1:0] CntOne = CW'(1);
  localparam logic [CW-1:0] CntFull = CW'(PathDepth);

  // Captured input word.
  pgnh_act_e               act_q;
  logic signed [CoordW-1:0] x_q, y_q;
  logic signed [SpeedW-1:0] spd_q;
  logic                     last_q;

  logic [CW-1:0] cnt_q;
  logic [AW-1:0] idx_q;
  logic [CW-1:0] cnt_m1;

  // Vertex store.
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;
  logic [VW-1:0] ram_wdata;
  logic signed [CoordW-1:0] rd_x, rd_y;
  logic [LenW-1:0] rd_len;

  // Distance pipeline.
  logic p1_q, p2_q;
  logic signed [CoordW:0] dx, dy;
  logic signed [2*CoordW+1:0] dx_sq, dy_sq;
  logic [SqW-1:0] dxsq_q, dysq_q;
  logic [LenW-1:0] len2_q;
  logic [DistW-1:0] dsq;
  logic [DistW-1:0] bd_q;
  logic [LenW-1:0]  blen_q;
  logic             first_q;
  logic [2*BndW-1:0] ibsq_q, wbsq_q;

  // Square root.
  logic [RadW-1:0]  rad_q;
  logic [RootW-1:0] root_q;
  logic [RemW-1:0]  rem_q;
  logic [RemW-1:0]  rem_sh, trial;
  logic [LenW:0]    len_sum;
  logic [LenW-1:0]  new_len;

  // Running values.
  logic                     open_q;
  logic [LenW-1:0]          best_q, wbest_q;
  logic signed [FarW-1:0]   far_q;
  logic signed [SpeedW-1:0] bspd_q;
  logic signed [CoordW-1:0] bx_q, by_q;
  logic [LenW-1:0]          inner_v, wide_v;
  logic signed [FarW-1:0]   far_v;
  logic                     trig;

  logic out_valid_q;
  logic out_free;

  assign cnt_m1 = cnt_q - CntOne;

  assign ram_re = cmd_i.rd_prev | cmd_i.scan_issue;
  assign ram_raddr = cmd_i.rd_prev ? cnt_m1[AW-1:0] : idx_q;
  assign ram_wdata = {x_q, y_q, new_len};
  assign rd_x = ram_rdata[VW-1 -: CoordW];
  assign rd_y = ram_rdata[LenW +: CoordW];
  assign rd_len = ram_rdata[LenW-1:0];

  pgnh_ram #(
    .Width(VW),
    .Depth(PathDepth)
  ) u_vtx (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_vertex),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign dx = {x_q[CoordW-1], x_q} - {rd_x[CoordW-1], rd_x};
  assign dy = {y_q[CoordW-1], y_q} - {rd_y[CoordW-1], rd_y};
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign dsq = {1'b0, dxsq_q} + {1'b0, dysq_q};

  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial = {root_q, 2'b01};
  assign len_sum = {1'b0, len2_q} + (LenW + 1)'(root_q);
  assign new_len = (cnt_q == '0) ? '0 :
                   (len_sum[LenW] ? {LenW{1'b1}} : len_sum[LenW-1:0]);

  assign inner_v = (cnt_q != '0 && {{(DistW-2*BndW){1'b0}}, ibsq_q} > bd_q) ? blen_q : no_hit_i;
  assign wide_v  = (cnt_q != '0 && {{(DistW-2*BndW){1'b0}}, wbsq_q} > bd_q) ? blen_q : no_hit_i;
  assign far_v   = (inner_v > FarLimit) ? FarNone : $signed({1'b0, inner_v});
  assign trig    = best_q < trig_lim_i;

  assign out_free = !out_valid_q || !out_stall_i;

  // Control flags: count, address, pipeline valids, frame open, result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      p1_q <= 1'b0;
      p2_q <= 1'b0;
      open_q <= 1'b0;
      out_valid_q <= 1'b0;
      act_q <= ACT_NONE;
    end else begin
      if (cmd_i.capture) begin
        act_q <= pgnh_act_e'(action_i);
      end
      if (cmd_i.clr_count) begin
        cnt_q <= '0;
      end else if (cmd_i.wr_vertex) begin
        cnt_q <= cnt_q + CntOne;
      end
      if (cmd_i.scan_init) begin
        idx_q <= '0;
      end else if (cmd_i.scan_issue) begin
        idx_q <= idx_q + AW'(1);
      end
      p1_q <= ram_re;
      p2_q <= p1_q;
      if (cmd_i.load_out) begin
        open_q <= 1'b0;
      end else if (cmd_i.fold) begin
        open_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q <= pos_x_i;
      y_q <= pos_y_i;
      spd_q <= obj_speed_in_i;
      last_q <= frame_last_i;
    end
    ibsq_q <= inner_bnd_i * inner_bnd_i;
    wbsq_q <= wide_bnd_i * wide_bnd_i;
    if (cmd_i.scan_init) begin
      first_q <= 1'b1;
    end
    if (p1_q) begin
      dxsq_q <= dx_sq[SqW-1:0];
      dysq_q <= dy_sq[SqW-1:0];
      len2_q <= rd_len;
    end
    if (p2_q) begin
      if (act_q == ACT_APPEND) begin
        rad_q <= {1'b0, dsq};
        root_q <= '0;
        rem_q <= '0;
      end else begin
        // Keep the first vertex on ties.
        if (first_q || dsq < bd_q) begin
          bd_q <= dsq;
          blen_q <= len2_q;
        end
        first_q <= 1'b0;
      end
    end
    if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q <= rem_sh - trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (cmd_i.fold) begin
      if (!open_q || inner_v < best_q) begin
        best_q <= inner_v;
        bspd_q <= spd_q;
        bx_q <= x_q;
        by_q <= y_q;
      end
      if (!open_q || wide_v < wbest_q) begin
        wbest_q <= wide_v;
      end
      if (!open_q || far_v > far_q) begin
        far_q <= far_v;
      end
    end
    if (cmd_i.load_out) begin
      if (cnt_q == '0) begin
        status_o <= 1'b1;
        trigger_o <= 1'b0;
        path_distance_o <= '0;
        wide_distance_o <= '0;
        farthest_o <= '0;
        nearest_speed_o <= '0;
        hit_x_o <= '0;
        hit_y_o <= '0;
      end else begin
        status_o <= 1'b0;
        trigger_o <= trig;
        path_distance_o <= best_q;
        wide_distance_o <= wbest_q;
        farthest_o <= far_q;
        nearest_speed_o <= trig ? bspd_q : '0;
        hit_x_o <= trig ? bx_q : DefaultPos;
        hit_y_o <= trig ? by_q : DefaultPos;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.action    = act_q;
  assign stat_o.last      = last_q;
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.cnt_full  = (cnt_q == CntFull);
  assign stat_o.scan_last = (idx_q == cnt_m1[AW-1:0]);
  assign stat_o.pipe_busy = p1_q | p2_q;
  assign stat_o.sq_ready  = p2_q;
  assign stat_o.out_free  = out_free;

endmodule

### hdl/pgnh_ctrl.sv
// Controller: sequences clear, append, scan, fold and result emission.
module pgnh_ctrl
  import pgnh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  pgnh_stat_t stat_i,
  output pgnh_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_APP_WAIT,
    ST_SQRT,
    ST_APP_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_FOLD,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          unique case (stat_i.action)
            ACT_CLEAR: state_q <= ST_IDLE;
            ACT_APPEND: begin
              if (stat_i.cnt_full) begin
                state_q <= ST_IDLE;
              end else if (stat_i.cnt_zero) begin
                state_q <= ST_APP_WR;
              end else begin
                state_q <= ST_APP_WAIT;
              end
            end
            ACT_POINT: state_q <= stat_i.cnt_zero ? ST_FOLD : ST_SCAN;
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_APP_WAIT: begin
          if (stat_i.sq_ready) begin
            step_q <= '0;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(SqrtSteps - 1)) begin
            state_q <= ST_APP_WR;
          end
        end
        ST_APP_WR: state_q <= ST_IDLE;
        ST_SCAN: begin
          if (stat_i.scan_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!stat_i.pipe_busy) begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: state_q <= stat_i.last ? ST_EMIT : ST_IDLE;
        ST_EMIT: begin
          if (stat_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o = '0;
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    unique case (state_q)
      ST_DISPATCH: begin
        cmd_o.clr_count = (stat_i.action == ACT_CLEAR);
        cmd_o.rd_prev = (stat_i.action == ACT_APPEND) && !stat_i.cnt_full && !stat_i.cnt_zero;
        cmd_o.scan_init = (stat_i.action == ACT_POINT);
      end
      ST_SQRT:   cmd_o.sqrt_step = 1'b1;
      ST_APP_WR: cmd_o.wr_vertex = 1'b1;
      ST_SCAN:   cmd_o.scan_issue = 1'b1;
      ST_FOLD:   cmd_o.fold = 1'b1;
      ST_EMIT:   cmd_o.load_out = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

### hdl/path_geofence_nearest_hit.sv
// Top level of the path geofence nearest-hit block: config registers, controller, datapath.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-------------------------------------------
//  in      | input     | in_valid_i/in_stall_o | action, pos_x, pos_y, obj_speed_in, last
//  out     | output    | out_valid_o/out_stall_i | status, trigger, distances, nearest obj
//  cfg     | input     | APB psel/penable      | inner, wide, trigger limit, no-hit distance
//
// Sequence: a clear returns straight to idle; an append on an empty path writes at once,
// else it reads the last vertex, squares, finds one root bit per cycle, then writes.
// An object point scans all N stored vertices (none on an empty path):
// the vertex RAM read port delivers one vertex per cycle into a two-stage
// square-and-compare pipe. A closing point then loads the result word once the output is free.
// Reset clears control state only; the vertex RAM is not cleared and only
// entries below the vertex count are read. A stalled result word holds while
// the next input word is taken; a second result waits for the first to leave.
module path_geofence_nearest_hit
  import pgnh_pkg::*;
#(
  parameter int unsigned PATH_DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input word
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [SpeedW-1:0] obj_speed_in_i,
  input  logic                     frame_last_i,
  // result word
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     status_o,
  output logic                     trigger_o,
  output logic [LenW-1:0]          path_distance_o,
  output logic [LenW-1:0]          wide_distance_o,
  output logic signed [FarW-1:0]   farthest_o,
  output logic signed [SpeedW-1:0] nearest_speed_o,
  output logic signed [CoordW-1:0] hit_x_o,
  output logic signed [CoordW-1:0] hit_y_o,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [BndW-1:0] inner_q, wide_q;
  logic [LenW-1:0] trig_q, nohit_q;
  logic            cfg_wr;
  pgnh_reg_e       reg_sel;
  pgnh_cmd_t       cmd;
  pgnh_stat_t      stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign reg_sel = pgnh_reg_e'(paddr[3:2]);

  // Write the selected register in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= InnerReset;
      wide_q <= WideReset;
      trig_q <= TriggerReset;
      nohit_q <= NoHitReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_INNER:   inner_q <= pwdata[BndW-1:0];
        REG_WIDE:    wide_q <= pwdata[BndW-1:0];
        REG_TRIGGER: trig_q <= pwdata;
        REG_NOHIT:   nohit_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_INNER:   prdata = {16'd0, inner_q};
      REG_WIDE:    prdata = {16'd0, wide_q};
      REG_TRIGGER: prdata = trig_q;
      REG_NOHIT:   prdata = nohit_q;
      default:     prdata = '0;
    endcase
  end

  pgnh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pgnh_datapath #(
    .PathDepth(PATH_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (action_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .obj_speed_in_i (obj_speed_in_i),
    .frame_last_i   (frame_last_i),
    .inner_bnd_i    (inner_q),
    .wide_bnd_i     (wide_q),
    .trig_lim_i     (trig_q),
    .no_hit_i       (nohit_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .trigger_o      (trigger_o),
    .path_distance_o(path_distance_o),
    .wide_distance_o(wide_distance_o),
    .farthest_o     (farthest_o),
    .nearest_speed_o(nearest_speed_o),
    .hit_x_o        (hit_x_o),
    .hit_y_o        (hit_y_o)
  );

endmodule

### tb/sv/tb.sv
// Testbench for path_geofence_nearest_hit: directed and random words, self-checking scoreboard.
`timescale 1ns / 1ps

module tb;
  import pgnh_pkg::*;

  localparam int Depth = 256;
  localparam int SettleCycles = 1100;   // enough for one scan of a full path plus an append
  localparam int LongHold = 3000;

  typedef struct {
    pgnh_act_e                act;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [SpeedW-1:0] spd;
    logic                     last;
  } geo_word_t;

  typedef struct {
    logic                     status;
    logic                     trigger;
    logic [LenW-1:0]          pdist;
    logic [LenW-1:0]          wide;
    logic signed [FarW-1:0]   far;
    logic signed [SpeedW-1:0] spd;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } frame_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_act = ACT_CLEAR;
  logic signed [CoordW-1:0] in_x = '0;
  logic signed [CoordW-1:0] in_y = '0;
  logic signed [SpeedW-1:0] in_spd = '0;
  logic                     in_last = 1'b0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     res_status;
  logic                     res_trigger;
  logic [LenW-1:0]          res_dist;
  logic [LenW-1:0]          res_wide;
  logic signed [FarW-1:0]   res_far;
  logic signed [SpeedW-1:0] res_spd;
  logic signed [CoordW-1:0] res_x;
  logic signed [CoordW-1:0] res_y;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  path_geofence_nearest_hit #(
    .PATH_DEPTH(Depth)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (in_act),
    .pos_x_i        (in_x),
    .pos_y_i        (in_y),
    .obj_speed_in_i (in_spd),
    .frame_last_i   (in_last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (res_status),
    .trigger_o      (res_trigger),
    .path_distance_o(res_dist),
    .wide_distance_o(res_wide),
    .farthest_o     (res_far),
    .nearest_speed_o(res_spd),
    .hit_x_o        (res_x),
    .hit_y_o        (res_y),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Words waiting to be offered, and frame results waiting to come out.
  geo_word_t  word_q[$];
  frame_res_t frame_q[$];
  int errors = 0;

  // Handshake bookkeeping shared by the driver, receiver and monitor.
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_left = 0;
  int   hold_asked = 0;
  int   hold_given = 0;
  bit   calm = 0;

  // Mirror of the configuration registers.
  logic [BndW-1:0] cfg_inner = InnerReset;
  logic [BndW-1:0] cfg_wide = WideReset;
  logic [LenW-1:0] cfg_trig = TriggerReset;
  logic [LenW-1:0] cfg_nohit = NoHitReset;

  // Predictor state: stored path and the running values of the open frame.
  logic signed [CoordW-1:0] path_x[Depth];
  logic signed [CoordW-1:0] path_y[Depth];
  logic [LenW-1:0]          path_len[Depth];
  int                       path_cnt = 0;
  logic [LenW-1:0]          near_dist = NoHitReset;
  logic [LenW-1:0]          near_wide = NoHitReset;
  logic signed [SpeedW-1:0] near_spd = '0;
  logic signed [CoordW-1:0] near_x = '0;
  logic signed [CoordW-1:0] near_y = '0;
  longint                   far_best = 0;
  bit                       frame_open = 0;

  // Coordinates of the path the stimulus is building, used to aim points.
  int route_x[$];
  int route_y[$];

  function automatic longint unsigned sq_span(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void reopen_frame();
    near_dist = cfg_nohit;
    near_wide = cfg_nohit;
    near_spd = '0;
    near_x = '0;
    near_y = '0;
    far_best = 0;
    frame_open = 0;
  endfunction

  // Advance the predictor by one accepted word; queue the frame result it closes.
  function automatic void track_word(geo_word_t w);
    longint unsigned bd, d, s;
    int bi;
    logic [LenW-1:0] inner_v, wide_v;
    longint far_v;
    frame_res_t r;
    case (w.act)
      ACT_CLEAR: path_cnt = 0;
      ACT_APPEND: begin
        if (path_cnt < Depth) begin
          s = 0;
          if (path_cnt > 0) begin
            s = longint'(path_len[path_cnt-1]) +
                root_floor(sq_span(w.x, w.y, path_x[path_cnt-1], path_y[path_cnt-1]));
            if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
          end
          path_x[path_cnt] = w.x;
          path_y[path_cnt] = w.y;
          path_len[path_cnt] = s[LenW-1:0];
          path_cnt++;
        end
      end
      ACT_POINT: begin
        inner_v = cfg_nohit;
        wide_v = cfg_nohit;
        if (path_cnt > 0) begin
          bd = sq_span(w.x, w.y, path_x[0], path_y[0]);
          bi = 0;
          for (int i = 1; i < path_cnt; i++) begin
            d = sq_span(w.x, w.y, path_x[i], path_y[i]);
            if (d < bd) begin
              bd = d;
              bi = i;
            end
          end
          if (bd < longint'(cfg_inner) * longint'(cfg_inner)) inner_v = path_len[bi];
          if (bd < longint'(cfg_wide) * longint'(cfg_wide)) wide_v = path_len[bi];
        end
        far_v = (inner_v > FarLimit) ? longint'(FarNone) : longint'(inner_v);
        if (!frame_open || inner_v < near_dist) begin
          near_dist = inner_v;
          near_spd = w.spd;
          near_x = w.x;
          near_y = w.y;
        end
        if (!frame_open || wide_v < near_wide) near_wide = wide_v;
        if (!frame_open || far_v > far_best) far_best = far_v;
        frame_open = 1;
        if (w.last) begin
          if (path_cnt == 0) begin
            r = '{status: 1'b1, trigger: 1'b0, pdist: '0, wide: '0, far: '0,
                  spd: '0, x: '0, y: '0};
          end else begin
            r.status = 1'b0;
            r.trigger = near_dist < cfg_trig;
            r.pdist = near_dist;
            r.wide = near_wide;
            r.far = far_best[FarW-1:0];
            r.spd = r.trigger ? near_spd : '0;
            r.x = r.trigger ? near_x : DefaultPos;
            r.y = r.trigger ? near_y : DefaultPos;
          end
          frame_q.insert(frame_q.size(), r);
          reopen_frame();
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag(string what, longint got, longint want);
    $display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_frame();
    frame_res_t e;
    if (frame_q.size() == 0) begin
      flag("result word with nothing pending, path_distance", res_dist, -1);
    end else begin
      e = frame_q.pop_front();
      if (res_status !== e.status) flag("status", res_status, e.status);
      if (res_trigger !== e.trigger) flag("trigger", res_trigger, e.trigger);
      if (res_dist !== e.pdist) flag("path_distance", res_dist, e.pdist);
      if (res_wide !== e.wide) flag("wide_distance", res_wide, e.wide);
      if (res_far !== e.far) flag("farthest", res_far, e.far);
      if (res_spd !== e.spd) flag("nearest_speed", res_spd, e.spd);
      if (res_x !== e.x) flag("hit_x", res_x, e.x);
      if (res_y !== e.y) flag("hit_y", res_y, e.y);
    end
  endtask

  // Monitor: sample both handshakes at the rising edge.
  always @(posedge clk) begin
    geo_word_t w;
    in_taken <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) begin
      w = '{act: pgnh_act_e'(in_act), x: in_x, y: in_y, spd: in_spd, last: in_last};
      track_word(w);
    end
    if (rst_n && out_valid && !out_stall) check_frame();
  end

  // Driver: hold a stalled word, otherwise wait out the drawn gap and offer the next.
  always @(negedge clk) begin
    geo_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (word_q.size() > 0) begin
      w = word_q.pop_front();
      in_act <= w.act;
      in_x <= w.x;
      in_y <= w.y;
      in_spd <= w.spd;
      in_last <= w.last;
      in_valid <= 1'b1;
      send_gap = calm ? 0 : $urandom_range(0, 4);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall for a drawn count after each result, or for a long hold on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_asked != hold_given) begin
      hold_given++;
      hold_left = LongHold;
      out_stall <= 1'b1;
    end else if (out_taken) begin
      recv_gap = calm ? 0 : $urandom_range(0, 4);
      out_stall <= recv_gap > 0;
      if (recv_gap > 0) recv_gap--;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic put(pgnh_act_e a, int x, int y, int spd, bit last);
    geo_word_t w;
    w = '{act: a, x: x[CoordW-1:0], y: y[CoordW-1:0], spd: spd[SpeedW-1:0], last: last};
    word_q.insert(word_q.size(), w);
    if (a == ACT_CLEAR) begin
      route_x.delete();
      route_y.delete();
    end else if (a == ACT_APPEND && route_x.size() < Depth) begin
      route_x.insert(route_x.size(), x);
      route_y.insert(route_y.size(), y);
    end
  endtask

  // Drop an object point near a random path vertex, or anywhere if there is no path and now and then otherwise.
  task automatic put_point(int spread, bit last);
    int k;
    if (route_x.size() == 0 || $urandom_range(0, 4) == 0) begin
      put(ACT_POINT, $urandom(), $urandom(), $urandom(), last);
    end else begin
      k = $urandom_range(0, route_x.size() - 1);
      put(ACT_POINT, route_x[k] + $urandom_range(0, 2 * spread) - spread,
          route_y[k] + $urandom_range(0, 2 * spread) - spread, $urandom(), last);
    end
  endtask

  task automatic cfg_write(pgnh_reg_e r, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_INNER:   cfg_inner = v[BndW-1:0];
      REG_WIDE:    cfg_wide = v[BndW-1:0];
      REG_TRIGGER: cfg_trig = v;
      default:     cfg_nohit = v;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until every word is in and every result out, then let the block finish its scan.
  task automatic settle();
    @(posedge clk);
    while (word_q.size() != 0 || in_valid || frame_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic pick_config(int kind);
    logic [31:0] a, b;
    case (kind)
      0: begin
        cfg_write(REG_INNER, InnerReset);
        cfg_write(REG_WIDE, WideReset);
        cfg_write(REG_TRIGGER, TriggerReset);
        cfg_write(REG_NOHIT, NoHitReset);
      end
      1: begin
        cfg_write(REG_INNER, '0);
        cfg_write(REG_WIDE, '0);
        cfg_write(REG_TRIGGER, '0);
        cfg_write(REG_NOHIT, '0);
      end
      2: begin
        cfg_write(REG_INNER, 32'hFFFF);
        cfg_write(REG_WIDE, 32'hFFFF);
        cfg_write(REG_TRIGGER, 32'hFFFF_FFFF);
        cfg_write(REG_NOHIT, 32'hFFFF_FFFF);
      end
      3: begin
        a = $urandom_range(100, 2000);
        b = a + $urandom_range(0, 600);
        cfg_write(REG_INNER, a);
        cfg_write(REG_WIDE, b);
        cfg_write(REG_TRIGGER, $urandom_range(0, 200000));
        cfg_write(REG_NOHIT, $urandom());
      end
      default: begin
        cfg_write(REG_INNER, 32'hFFFF);
        cfg_write(REG_WIDE, InnerReset);
        cfg_write(REG_TRIGGER, $urandom());
        cfg_write(REG_NOHIT, $urandom_range(60000, 90000));
      end
    endcase
  endtask

  initial begin
    int made, n, step, cx, cy, frames, pts, spread;
    made = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty path, ignored flags, ties, extremes, clear inside a frame.
    put(ACT_POINT, 10, 20, 7, 1);
    put(ACT_CLEAR, 0, 0, 0, 1);
    put(ACT_APPEND, 0, 0, 0, 1);
    put(ACT_APPEND, 300, 400, 0, 0);
    put(ACT_APPEND, -8388608, -8388608, 0, 0);
    put(ACT_APPEND, 8388607, 8388607, 0, 0);
    put(ACT_POINT, 150, 200, -32768, 0);
    put(ACT_POINT, 300, 400, 32767, 0);
    put(ACT_NONE, -1, -1, -1, 1);
    put(ACT_POINT, 8388607, -8388608, 0, 0);
    put(ACT_CLEAR, 0, 0, 0, 0);
    put(ACT_APPEND, 0, 0, 0, 0);
    put(ACT_POINT, 0, 0, 5, 1);
    put(ACT_POINT, 0, 1, 6, 0);
    put(ACT_POINT, 1, 0, 9, 1);
    put(ACT_POINT, -8388608, 8388607, 1, 1);
    made += 16;
    settle();

    // Full path along opposite corners: length saturates, extra appends drop.
    put(ACT_CLEAR, 0, 0, 0, 0);
    for (int i = 0; i < Depth + 6; i++) begin
      if (i % 2 == 0) put(ACT_APPEND, -8388608, -8388608, 0, 0);
      else put(ACT_APPEND, 8388607, 8388607, 0, 0);
    end
    for (int f = 0; f < 6; f++) begin
      put(ACT_POINT, -8388608 + f, -8388608, $urandom(), 0);
      put(ACT_POINT, 8388607 - f, 8388607, $urandom(), 1);
    end
    made += Depth + 19;
    settle();

    for (int ph = 0; made < 580; ph++) begin
      settle();
      pick_config(ph < 3 ? ph + 1 : $urandom_range(0, 4));
      calm = ($urandom_range(0, 3) == 0);
      spread = (cfg_wide > cfg_inner ? cfg_wide : cfg_inner) + 200;
      if (spread > 4000) spread = 4000;
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
      step = $urandom_range(64, 3000);
      cx = $urandom_range(0, 8000000) - 4000000;
      cy = $urandom_range(0, 8000000) - 4000000;
      put(ACT_CLEAR, 0, 0, 0, $urandom_range(0, 1));
      made++;
      for (int i = 0; i < n; i++) begin
        cx += $urandom_range(0, 2 * step) - step;
        cy += $urandom_range(0, 2 * step) - step;
        put(ACT_APPEND, cx, cy, $urandom(), $urandom_range(0, 7) == 0);
        made++;
      end
      // Once, hold the result side for a long stretch while single-point frames pile up.
      if (ph == 1) begin
        hold_asked++;
        for (int i = 0; i < 8; i++) put_point(spread, 1);
        made += 8;
      end
      frames = $urandom_range(2, 6);
      for (int f = 0; f < frames; f++) begin
        pts = $urandom_range(1, 5);
        for (int p = 0; p < pts; p++) begin
          if ($urandom_range(0, 15) == 0) put(ACT_NONE, $urandom(), $urandom(), $urandom(), 1);
          if ($urandom_range(0, 30) == 0) begin
            put(ACT_CLEAR, 0, 0, 0, 0);
            put(ACT_APPEND, cx, cy, 0, 0);
            made += 2;
          end
          put_point(spread, p == pts - 1);
          made++;
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### path_geofence_nearest_hit.f
hdl/pgnh_pkg.sv
hdl/pgnh_ram.sv
hdl/pgnh_datapath.sv
hdl/pgnh_ctrl.sv
hdl/path_geofence_nearest_hit.sv
tb/sv/tb.sv
